[rtl/rmts_pkg.sv]
// Shared types, constants and helpers of the rate monotonic tick scheduler.
package rmts_pkg;

   localparam int TASK_W = 3;
   localparam int TASK_SLOTS = 8;
   localparam int CSR_REGS = 3;
   localparam int CSR_INDEX_W = 2;

   localparam logic [63:0] TASK0_RESET = 64'd42949804042;
   localparam logic [63:0] TASK1_RESET = 64'd64424706063;
   localparam logic [63:0] TASK2_RESET = 64'd85899608084;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_REL_START,
      ST_REL_DIV,
      ST_RUN_MISS,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_SCAN_MV,
      ST_BEST_RD,
      ST_BEST_CHK,
      ST_DISPATCH,
      ST_MOVE_WR,
      ST_EXEC,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic start;
      logic busy;
      logic done;
      logic zero;
   } rem_ctl_type;

   function automatic logic [31:0] sat_inc(input logic [31:0] v);
      sat_inc = (v != 32'hFFFF_FFFF) ? v + 32'd1 : v;
   endfunction

endpackage

[rtl/rate_monotonic_tick_scheduler_unit.sv]
// Top level of the rate monotonic tick scheduler with its ready queue memory.
// A word with advance low returns the status in the cycle after it is taken. A tick
// runs a release check per task (one remainder bit a cycle), a deadline sweep that
// reads and checks each queued job and moves the last one into a dropped job's slot,
// a priority sweep over the remaining jobs, then dispatch, a move when needed, execute
// and done; the registered reads of the queue memory set the sweep cost. One tick is in
// flight at a time; the next word is taken once the result is loaded and not held by rsp_stall.
module rate_monotonic_tick_scheduler_unit #(
   parameter int NUM_TASKS   = 3,
   parameter int QUEUE_DEPTH = 128,
   parameter int TIME_BITS   = 48
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_advance,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_cpu_running,
   output logic [rmts_pkg::TASK_W-1:0]      rsp_running_task,
   output logic [15:0]                      rsp_running_seq,
   output logic [7:0]                       rsp_released_mask,
   output logic [7:0]                       rsp_missed_now,
   output logic                             rsp_started,
   output logic                             rsp_preempted,
   output logic                             rsp_finished,
   output logic                             rsp_overflow_drop,
   output logic [31:0]                      rsp_total_completed,
   output logic [31:0]                      rsp_total_preemptions,
   output logic [31:0]                      rsp_total_misses,
   input  logic                             csr_write_enable,
   input  logic [rmts_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [63:0]                      csr_write_data
);
   import rmts_pkg::*;

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   state_type state_ff, state_in;

   logic [63:0] cfg_ff [TASK_SLOTS];
   logic [15:0] rel_seq_ff [TASK_SLOTS];

   logic [TASK_W-1:0]    mem_task [QUEUE_DEPTH];
   logic [TIME_BITS-1:0] mem_dl   [QUEUE_DEPTH];
   logic [15:0]          mem_rem  [QUEUE_DEPTH];
   logic [15:0]          mem_seq  [QUEUE_DEPTH];

   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   logic [TASK_W-1:0]    wr_task;
   logic [TIME_BITS-1:0] wr_dl;
   logic [15:0]          wr_rem, wr_seq;
   logic                 rd_en;
   logic [AW-1:0]        rd_addr;
   logic [TASK_W-1:0]    rd_task_ff;
   logic [TIME_BITS-1:0] rd_dl_ff;
   logic [15:0]          rd_rem_ff, rd_seq_ff;

   logic [TIME_BITS-1:0] now_ff, now_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [CW-1:0]        idx_ff, idx_in;
   logic [TASK_W-1:0]    tsk_ff, tsk_in;
   logic                 busy_ff, busy_in;
   logic [TASK_W-1:0]    run_task_ff, run_task_in;
   logic [TIME_BITS-1:0] run_dl_ff, run_dl_in;
   logic [15:0]          run_rem_ff, run_rem_in;
   logic [15:0]          run_seq_ff, run_seq_in;
   logic                 have_best_ff, have_best_in;
   logic [AW-1:0]        best_idx_ff, best_idx_in;
   logic [TASK_W-1:0]    best_task_ff, best_task_in;
   logic [TIME_BITS-1:0] best_dl_ff, best_dl_in;
   logic [15:0]          best_rem_ff, best_rem_in;
   logic [15:0]          best_seq_ff, best_seq_in;
   logic [7:0]           released_ff, released_in;
   logic [7:0]           missed_ff, missed_in;
   logic                 started_ff, started_in;
   logic                 preempt_ff, preempt_in;
   logic                 finished_ff, finished_in;
   logic                 ovf_ff, ovf_in;
   logic [31:0]          cnt_done_ff, cnt_done_in;
   logic [31:0]          cnt_pre_ff, cnt_pre_in;
   logic [31:0]          cnt_miss_ff, cnt_miss_in;
   logic                 seq_inc;
   logic                 load_rsp, load_idle;
   logic                 rsp_valid_ff;

   logic                 rem_start;
   logic [TIME_BITS-1:0] rem_dividend;
   rem_ctl_type          rem_status;

   logic [63:0]          cur_word;
   logic [15:0]          cur_period, cur_phase, cur_dl, cur_wcet;
   logic [15:0]          rd_period, best_period, run_period;
   logic [15:0]          exec_rem;

   function automatic logic [15:0] period_of(input logic [TASK_W-1:0] t,
                                             input logic [63:0] w);
      period_of = (32'(t) < NUM_TASKS) ? w[15:0] : 16'd0;
   endfunction

   rmts_rem_unit #(.TIME_BITS(TIME_BITS)) u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (rem_start),
      .dividend (rem_dividend),
      .divisor  (cur_period),
      .status   (rem_status)
   );

   assign cur_word     = cfg_ff[tsk_ff];
   assign cur_period   = (32'(tsk_ff) < NUM_TASKS) ? cur_word[15:0] : 16'd0;
   assign cur_wcet     = cur_word[31:16];
   assign cur_dl       = cur_word[47:32];
   assign cur_phase    = cur_word[63:48];
   assign rem_dividend = now_ff - TIME_BITS'(cur_phase);
   assign rd_period    = period_of(rd_task_ff, cfg_ff[rd_task_ff]);
   assign best_period  = period_of(best_task_ff, cfg_ff[best_task_ff]);
   assign run_period   = period_of(run_task_ff, cfg_ff[run_task_ff]);
   assign exec_rem     = (run_rem_ff != '0) ? run_rem_ff - 16'd1 : run_rem_ff;

   assign req_stall = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign load_idle = (state_ff == ST_IDLE) && req_valid && !req_stall;

   always_ff @(posedge clock) begin
      state_ff <= reset ? ST_IDLE : state_in;
   end

   always_comb begin
      state_in     = state_ff;
      now_in       = now_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      tsk_in       = tsk_ff;
      busy_in      = busy_ff;
      run_task_in  = run_task_ff;
      run_dl_in    = run_dl_ff;
      run_rem_in   = run_rem_ff;
      run_seq_in   = run_seq_ff;
      have_best_in = have_best_ff;
      best_idx_in  = best_idx_ff;
      best_task_in = best_task_ff;
      best_dl_in   = best_dl_ff;
      best_rem_in  = best_rem_ff;
      best_seq_in  = best_seq_ff;
      released_in  = released_ff;
      missed_in    = missed_ff;
      started_in   = started_ff;
      preempt_in   = preempt_ff;
      finished_in  = finished_ff;
      ovf_in       = ovf_ff;
      cnt_done_in  = cnt_done_ff;
      cnt_pre_in   = cnt_pre_ff;
      cnt_miss_in  = cnt_miss_ff;
      seq_inc      = 1'b0;
      rem_start    = 1'b0;
      load_rsp     = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = count_ff[AW-1:0];
      wr_task      = tsk_ff;
      wr_dl        = now_ff + TIME_BITS'(cur_dl);
      wr_rem       = cur_wcet;
      wr_seq       = rel_seq_ff[tsk_ff];
      rd_en        = 1'b0;
      rd_addr      = idx_ff[AW-1:0];
      case (state_ff)
         ST_IDLE: begin
            if (load_idle) begin
               released_in = '0;
               missed_in   = '0;
               started_in  = 1'b0;
               preempt_in  = 1'b0;
               finished_in = 1'b0;
               ovf_in      = 1'b0;
               if (req_advance) begin
                  tsk_in   = '0;
                  state_in = ST_REL_START;
               end else begin
                  load_rsp = 1'b1;
               end
            end
         end
         ST_REL_START: begin
            if (cur_period == '0 || now_ff < TIME_BITS'(cur_phase)) begin
               if (32'(tsk_ff) == NUM_TASKS - 1) begin
                  state_in = ST_RUN_MISS;
               end else begin
                  tsk_in = tsk_ff + TASK_W'(1);
               end
            end else begin
               rem_start = 1'b1;
               state_in  = ST_REL_DIV;
            end
         end
         ST_REL_DIV: begin
            if (rem_status.done) begin
               if (rem_status.zero) begin
                  released_in[tsk_ff] = 1'b1;
                  seq_inc             = 1'b1;
                  if (count_ff < CW'(QUEUE_DEPTH)) begin
                     wr_en    = 1'b1;
                     count_in = count_ff + CW'(1);
                  end else begin
                     ovf_in = 1'b1;
                  end
               end
               if (32'(tsk_ff) == NUM_TASKS - 1) begin
                  state_in = ST_RUN_MISS;
               end else begin
                  tsk_in   = tsk_ff + TASK_W'(1);
                  state_in = ST_REL_START;
               end
            end
         end
         ST_RUN_MISS: begin
            if (busy_ff && now_ff > run_dl_ff && run_rem_ff != '0) begin
               missed_in   = missed_ff + 8'd1;
               cnt_miss_in = sat_inc(cnt_miss_ff);
               busy_in     = 1'b0;
            end
            idx_in   = '0;
            state_in = ST_SCAN_RD;
         end
         ST_SCAN_RD: begin
            if (idx_ff >= count_ff) begin
               idx_in       = '0;
               have_best_in = 1'b0;
               state_in     = ST_BEST_RD;
            end else begin
               rd_en    = 1'b1;
               state_in = ST_SCAN_CHK;
            end
         end
         ST_SCAN_CHK: begin
            if (now_ff > rd_dl_ff && rd_rem_ff != '0) begin
               missed_in   = missed_ff + 8'd1;
               cnt_miss_in = sat_inc(cnt_miss_ff);
               count_in    = count_ff - CW'(1);
               if (idx_ff == count_ff - CW'(1)) begin
                  state_in = ST_SCAN_RD;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = count_in[AW-1:0];
                  state_in = ST_SCAN_MV;
               end
            end else begin
               idx_in   = idx_ff + CW'(1);
               state_in = ST_SCAN_RD;
            end
         end
         ST_SCAN_MV: begin
            wr_en    = 1'b1;
            wr_addr  = idx_ff[AW-1:0];
            wr_task  = rd_task_ff;
            wr_dl    = rd_dl_ff;
            wr_rem   = rd_rem_ff;
            wr_seq   = rd_seq_ff;
            state_in = ST_SCAN_RD;
         end
         ST_BEST_RD: begin
            if (idx_ff >= count_ff) begin
               state_in = ST_DISPATCH;
            end else begin
               rd_en    = 1'b1;
               state_in = ST_BEST_CHK;
            end
         end
         ST_BEST_CHK: begin
            if (!have_best_ff || rd_period < best_period ||
                (rd_period == best_period && (rd_dl_ff < best_dl_ff ||
                 (rd_dl_ff == best_dl_ff && rd_task_ff < best_task_ff)))) begin
               have_best_in = 1'b1;
               best_idx_in  = idx_ff[AW-1:0];
               best_task_in = rd_task_ff;
               best_dl_in   = rd_dl_ff;
               best_rem_in  = rd_rem_ff;
               best_seq_in  = rd_seq_ff;
            end
            idx_in   = idx_ff + CW'(1);
            state_in = ST_BEST_RD;
         end
         ST_DISPATCH: begin
            state_in = ST_EXEC;
            if (have_best_ff && !busy_ff) begin
               run_task_in = best_task_ff;
               run_dl_in   = best_dl_ff;
               run_rem_in  = best_rem_ff;
               run_seq_in  = best_seq_ff;
               busy_in     = 1'b1;
               started_in  = 1'b1;
               count_in    = count_ff - CW'(1);
               if (CW'(best_idx_ff) != count_in) begin
                  rd_en    = 1'b1;
                  rd_addr  = count_in[AW-1:0];
                  state_in = ST_MOVE_WR;
               end
            end else if (have_best_ff && best_period < run_period) begin
               wr_en       = 1'b1;
               wr_addr     = best_idx_ff;
               wr_task     = run_task_ff;
               wr_dl       = run_dl_ff;
               wr_rem      = run_rem_ff;
               wr_seq      = run_seq_ff;
               run_task_in = best_task_ff;
               run_dl_in   = best_dl_ff;
               run_rem_in  = best_rem_ff;
               run_seq_in  = best_seq_ff;
               cnt_pre_in  = sat_inc(cnt_pre_ff);
               preempt_in  = 1'b1;
            end
         end
         ST_MOVE_WR: begin
            wr_en    = 1'b1;
            wr_addr  = best_idx_ff;
            wr_task  = rd_task_ff;
            wr_dl    = rd_dl_ff;
            wr_rem   = rd_rem_ff;
            wr_seq   = rd_seq_ff;
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (busy_ff) begin
               run_rem_in = exec_rem;
               if (exec_rem == '0) begin
                  cnt_done_in = sat_inc(cnt_done_ff);
                  busy_in     = 1'b0;
                  finished_in = 1'b1;
               end
            end
            now_in   = now_ff + TIME_BITS'(1);
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_task[wr_addr] <= wr_task;
         mem_dl[wr_addr]   <= wr_dl;
         mem_rem[wr_addr]  <= wr_rem;
         mem_seq[wr_addr]  <= wr_seq;
      end
      if (rd_en) begin
         rd_task_ff <= mem_task[rd_addr];
         rd_dl_ff   <= mem_dl[rd_addr];
         rd_rem_ff  <= mem_rem[rd_addr];
         rd_seq_ff  <= mem_seq[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TASK_SLOTS; i++) begin
            cfg_ff[i]     <= (i == 0) ? TASK0_RESET :
                             (i == 1) ? TASK1_RESET :
                             (i == 2) ? TASK2_RESET : 64'd0;
            rel_seq_ff[i] <= '0;
         end
      end else begin
         if (csr_write_enable && 32'(csr_index) < CSR_REGS && 32'(csr_index) < NUM_TASKS) begin
            cfg_ff[TASK_W'(csr_index)] <= csr_write_data;
         end
         if (seq_inc) begin
            rel_seq_ff[tsk_ff] <= rel_seq_ff[tsk_ff] + 16'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         now_ff       <= '0;
         count_ff     <= '0;
         busy_ff      <= 1'b0;
         run_task_ff  <= '0;
         run_dl_ff    <= '0;
         run_rem_ff   <= '0;
         run_seq_ff   <= '0;
         cnt_done_ff  <= '0;
         cnt_pre_ff   <= '0;
         cnt_miss_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         now_ff       <= now_in;
         count_ff     <= count_in;
         busy_ff      <= busy_in;
         run_task_ff  <= run_task_in;
         run_dl_ff    <= run_dl_in;
         run_rem_ff   <= run_rem_in;
         run_seq_ff   <= run_seq_in;
         cnt_done_ff  <= cnt_done_in;
         cnt_pre_ff   <= cnt_pre_in;
         cnt_miss_ff  <= cnt_miss_in;
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      idx_ff       <= idx_in;
      tsk_ff       <= tsk_in;
      have_best_ff <= have_best_in;
      best_idx_ff  <= best_idx_in;
      best_task_ff <= best_task_in;
      best_dl_ff   <= best_dl_in;
      best_rem_ff  <= best_rem_in;
      best_seq_ff  <= best_seq_in;
      released_ff  <= released_in;
      missed_ff    <= missed_in;
      started_ff   <= started_in;
      preempt_ff   <= preempt_in;
      finished_ff  <= finished_in;
      ovf_ff       <= ovf_in;
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_cpu_running       <= busy_in;
         rsp_running_task      <= busy_in ? run_task_in : '0;
         rsp_running_seq       <= busy_in ? run_seq_in : '0;
         rsp_released_mask     <= released_in;
         rsp_missed_now        <= missed_in;
         rsp_started           <= started_in;
         rsp_preempted         <= preempt_in;
         rsp_finished          <= finished_in;
         rsp_overflow_drop     <= ovf_in;
         rsp_total_completed   <= cnt_done_in;
         rsp_total_preemptions <= cnt_pre_in;
         rsp_total_misses      <= cnt_miss_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(QUEUE_DEPTH))
      else $error("ready queue count beyond depth");
   a_start_xor_preempt: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_started && rsp_preempted))
      else $error("start and preemption in one tick");
   a_finish_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_finished) |-> !rsp_cpu_running)
      else $error("processor busy after completion");
   a_rem_start_idle: assert property (@(posedge clock) disable iff (reset)
      rem_status.start |-> !rem_status.busy)
      else $error("remainder unit restarted while busy");
`endif

endmodule

[rtl/rmts_rem_unit.sv]
// Bit-serial remainder unit: tests whether a time offset is a multiple of a period.
module rmts_rem_unit #(
   parameter int TIME_BITS = 48
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [TIME_BITS-1:0] dividend,
   input  logic [15:0]          divisor,
   output rmts_pkg::rem_ctl_type status
);
   import rmts_pkg::*;

   localparam int BW = $clog2(TIME_BITS);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [BW-1:0]        bit_ff, bit_in;
   logic [TIME_BITS-1:0] num_ff, num_in;
   logic [15:0]          den_ff, den_in;
   logic [15:0]          rem_ff, rem_in;
   logic [16:0]          shifted;

   always_comb begin
      shifted = {rem_ff, num_ff[bit_ff]};
      busy_in = busy_ff;
      done_in = 1'b0;
      bit_in  = bit_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         bit_in  = BW'(TIME_BITS - 1);
         num_in  = dividend;
         den_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, den_ff}) begin
            rem_in = 16'(shifted - {1'b0, den_ff});
         end else begin
            rem_in = shifted[15:0];
         end
         if (bit_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            bit_in = bit_ff - BW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      bit_ff <= bit_in;
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
   end

   assign status = '{start: start, busy: busy_ff, done: done_ff, zero: (rem_ff == '0)};

endmodule

[tb/sv/rate_monotonic_tick_scheduler_unit_tb.sv]
// Testbench for the rate monotonic tick scheduler: a tick-level scheduler mirror, random traffic.
module rate_monotonic_tick_scheduler_unit_tb;
   import rmts_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int QDEPTH = 128;
   localparam int WATCH_LIMIT = 20000;

   typedef struct packed {
      logic        cpu_running;
      logic [2:0]  running_task;
      logic [15:0] running_seq;
      logic [7:0]  released_mask;
      logic [7:0]  missed_now;
      logic        started;
      logic        preempted;
      logic        finished;
      logic        overflow_drop;
      logic [31:0] total_completed;
      logic [31:0] total_preemptions;
      logic [31:0] total_misses;
   } sched_status_t;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_advance;
   logic        rsp_valid;
   logic        rsp_stall;
   logic        rsp_cpu_running;
   logic [2:0]  rsp_running_task;
   logic [15:0] rsp_running_seq;
   logic [7:0]  rsp_released_mask;
   logic [7:0]  rsp_missed_now;
   logic        rsp_started;
   logic        rsp_preempted;
   logic        rsp_finished;
   logic        rsp_overflow_drop;
   logic [31:0] rsp_total_completed;
   logic [31:0] rsp_total_preemptions;
   logic [31:0] rsp_total_misses;
   logic        csr_write_enable;
   logic [1:0]  csr_index;
   logic [63:0] csr_write_data;

   rate_monotonic_tick_scheduler_unit dut (.*);

   // scheduler mirror
   logic [63:0] task_cfg [CSR_REGS];
   logic [47:0] cur_tick;
   int          ready_cnt;
   logic [2:0]  rq_task [QDEPTH];
   logic [47:0] rq_deadline [QDEPTH];
   logic [15:0] rq_remaining [QDEPTH];
   logic [15:0] rq_seq [QDEPTH];
   logic        run_active;
   logic [2:0]  cur_task;
   logic [47:0] cur_deadline;
   logic [15:0] cur_remaining;
   logic [15:0] cur_seq;
   logic [15:0] release_cnt [CSR_REGS];
   logic [31:0] done_total, preempt_total, miss_total;

   logic          pending_ticks [$];
   sched_status_t status_expected [$];
   int            err_count = 0;
   int            idle_cycles = 0;
   logic          hold_kick = 1'b0;
   logic          hold_done;
   int            hold_left;
   int            req_gap, rsp_gap;

   function automatic logic [15:0] period_of(input logic [2:0] id);
      return (id < CSR_REGS) ? task_cfg[id][15:0] : 16'd0;
   endfunction

   function automatic logic [31:0] sat_up(input logic [31:0] v);
      return (v != 32'hFFFF_FFFF) ? v + 32'd1 : v;
   endfunction

   function automatic void ready_remove(input int idx);
      ready_cnt--;
      rq_task[idx] = rq_task[ready_cnt];
      rq_deadline[idx] = rq_deadline[ready_cnt];
      rq_remaining[idx] = rq_remaining[ready_cnt];
      rq_seq[idx] = rq_seq[ready_cnt];
   endfunction

   function automatic sched_status_t schedule_tick(input logic adv);
      sched_status_t s;
      int best;
      int i;
      logic [15:0] p, ph, pa, pb;
      logic [2:0] tt;
      logic [47:0] td;
      logic [15:0] tr, ts;
      s = '0;
      if (adv) begin
         for (i = 0; i < CSR_REGS; i++) begin
            p = task_cfg[i][15:0];
            ph = task_cfg[i][63:48];
            if (p == 0 || cur_tick < 48'(ph) || ((cur_tick - 48'(ph)) % 48'(p)) != 0)
               continue;
            s.released_mask[i] = 1'b1;
            if (ready_cnt < QDEPTH) begin
               rq_task[ready_cnt] = 3'(i);
               rq_deadline[ready_cnt] = cur_tick + 48'(task_cfg[i][47:32]);
               rq_remaining[ready_cnt] = task_cfg[i][31:16];
               rq_seq[ready_cnt] = release_cnt[i];
               ready_cnt++;
            end else begin
               s.overflow_drop = 1'b1;
            end
            release_cnt[i] = release_cnt[i] + 16'd1;
         end
         if (run_active && cur_tick > cur_deadline && cur_remaining > 0) begin
            s.missed_now++;
            miss_total = sat_up(miss_total);
            run_active = 1'b0;
         end
         i = 0;
         while (i < ready_cnt) begin
            if (cur_tick > rq_deadline[i] && rq_remaining[i] > 0) begin
               s.missed_now++;
               miss_total = sat_up(miss_total);
               ready_remove(i);
            end else begin
               i++;
            end
         end
         best = (ready_cnt == 0) ? -1 : 0;
         for (i = 1; i < ready_cnt; i++) begin
            pa = period_of(rq_task[i]);
            pb = period_of(rq_task[best]);
            if (pa < pb)
               best = i;
            else if (pa == pb && (rq_deadline[i] < rq_deadline[best] ||
                  (rq_deadline[i] == rq_deadline[best] && rq_task[i] < rq_task[best])))
               best = i;
         end
         if (!run_active) begin
            if (best >= 0) begin
               cur_task = rq_task[best];
               cur_deadline = rq_deadline[best];
               cur_remaining = rq_remaining[best];
               cur_seq = rq_seq[best];
               ready_remove(best);
               run_active = 1'b1;
               s.started = 1'b1;
            end
         end else if (best >= 0 && period_of(rq_task[best]) < period_of(cur_task)) begin
            tt = rq_task[best];
            td = rq_deadline[best];
            tr = rq_remaining[best];
            ts = rq_seq[best];
            rq_task[best] = cur_task;
            rq_deadline[best] = cur_deadline;
            rq_remaining[best] = cur_remaining;
            rq_seq[best] = cur_seq;
            cur_task = tt;
            cur_deadline = td;
            cur_remaining = tr;
            cur_seq = ts;
            preempt_total = sat_up(preempt_total);
            s.preempted = 1'b1;
         end
         if (run_active) begin
            if (cur_remaining > 0)
               cur_remaining--;
            if (cur_remaining == 0) begin
               done_total = sat_up(done_total);
               run_active = 1'b0;
               s.finished = 1'b1;
            end
         end
         cur_tick = cur_tick + 48'd1;
      end
      s.cpu_running = run_active;
      s.running_task = run_active ? cur_task : 3'd0;
      s.running_seq = run_active ? cur_seq : 16'd0;
      s.total_completed = done_total;
      s.total_preemptions = preempt_total;
      s.total_misses = miss_total;
      return s;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 95)
         return $urandom_range(1, 3);
      return $urandom_range(20, 60);
   endfunction

   task automatic report_err(input string field, input logic [63:0] got, input logic [63:0] want);
      $display("mismatch %s: got %0h expected %0h", field, got, want);
      err_count++;
   endtask

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_advance <= 1'b0;
         req_gap <= 0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid)
            status_expected.push_back(schedule_tick(req_advance));
         if (req_gap > 0) begin
            req_gap <= req_gap - 1;
            req_valid <= 1'b0;
         end else if (pending_ticks.size() > 0) begin
            req_valid <= 1'b1;
            req_advance <= pending_ticks.pop_front();
            req_gap <= pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      sched_status_t want;
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_gap <= 0;
         hold_left <= 0;
         hold_done <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (status_expected.size() == 0) begin
               report_err("unexpected word", 0, 0);
            end else begin
               want = status_expected.pop_front();
               if (rsp_cpu_running !== want.cpu_running)
                  report_err("cpu_running", rsp_cpu_running, want.cpu_running);
               if (rsp_running_task !== want.running_task)
                  report_err("running_task", rsp_running_task, want.running_task);
               if (rsp_running_seq !== want.running_seq)
                  report_err("running_seq", rsp_running_seq, want.running_seq);
               if (rsp_released_mask !== want.released_mask)
                  report_err("released_mask", rsp_released_mask, want.released_mask);
               if (rsp_missed_now !== want.missed_now)
                  report_err("missed_now", rsp_missed_now, want.missed_now);
               if (rsp_started !== want.started)
                  report_err("started", rsp_started, want.started);
               if (rsp_preempted !== want.preempted)
                  report_err("preempted", rsp_preempted, want.preempted);
               if (rsp_finished !== want.finished)
                  report_err("finished", rsp_finished, want.finished);
               if (rsp_overflow_drop !== want.overflow_drop)
                  report_err("overflow_drop", rsp_overflow_drop, want.overflow_drop);
               if (rsp_total_completed !== want.total_completed)
                  report_err("total_completed", rsp_total_completed, want.total_completed);
               if (rsp_total_preemptions !== want.total_preemptions)
                  report_err("total_preemptions", rsp_total_preemptions,
                     want.total_preemptions);
               if (rsp_total_misses !== want.total_misses)
                  report_err("total_misses", rsp_total_misses, want.total_misses);
            end
         end
         if (hold_kick && !hold_done) begin
            hold_done <= 1'b1;
            hold_left <= 600;
            rsp_stall <= 1'b1;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_stall <= 1'b1;
         end else if (rsp_gap > 0) begin
            rsp_gap <= rsp_gap - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_gap <= pick_gap();
            rsp_stall <= 1'b0;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCH_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic csr_write(input logic [1:0] idx, input logic [63:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      if (idx < CSR_REGS)
         task_cfg[idx] = data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic wait_drained();
      while (pending_ticks.size() > 0 || req_valid || status_expected.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic push_ticks(input int n, input int pct_advance);
      for (int i = 0; i < n; i++)
         pending_ticks.push_back($urandom_range(0, 99) < pct_advance);
   endtask

   function automatic logic [63:0] rand_word();
      if ($urandom_range(0, 7) == 0)
         return {$urandom, $urandom};
      return {16'($urandom_range(0, 8)), 16'($urandom_range(0, 25)),
              16'($urandom_range(0, 6)), 16'($urandom_range(0, 12))};
   endfunction

   initial begin
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      task_cfg[0] = TASK0_RESET;
      task_cfg[1] = TASK1_RESET;
      task_cfg[2] = TASK2_RESET;
      cur_tick = '0;
      ready_cnt = 0;
      run_active = 1'b0;
      cur_task = '0;
      cur_deadline = '0;
      cur_remaining = '0;
      cur_seq = '0;
      for (int i = 0; i < CSR_REGS; i++)
         release_cnt[i] = '0;
      done_total = '0;
      preempt_total = '0;
      miss_total = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset configuration, status reads before and after
      pending_ticks.push_back(1'b0);
      for (int i = 0; i < 12; i++)
         pending_ticks.push_back(1'b1);
      pending_ticks.push_back(1'b0);
      wait_drained();

      // preemption, misses, zero wcet
      csr_write(0, {16'd3, 16'd5, 16'd1, 16'd5});
      csr_write(1, {16'd0, 16'd7, 16'd9, 16'd7});
      csr_write(2, {16'd0, 16'd40, 16'd0, 16'd40});
      csr_write(3, {$urandom, $urandom});
      push_ticks(12, 100);
      wait_drained();

      // extremes: all ones and disabled tasks
      csr_write(0, 64'hFFFF_FFFF_FFFF_FFFF);
      csr_write(1, 64'h0);
      csr_write(2, {16'd0, 16'hFFFF, 16'd0, 16'd1});
      push_ticks(60, 90);
      wait_drained();

      // fill the ready queue until it drops
      csr_write(0, {16'd0, 16'hFFFF, 16'hFFFF, 16'd1});
      csr_write(1, {16'd0, 16'hFFFF, 16'hFFFF, 16'd2});
      csr_write(2, {16'd0, 16'hFFFF, 16'h0001, 16'd3});
      push_ticks(150, 100);
      wait_drained();

      csr_write(0, 64'h0);
      csr_write(1, 64'h0);
      csr_write(2, 64'h0);
      push_ticks(40, 80);
      wait_drained();

      for (int ph = 0; ph < 8; ph++) begin
         for (int r = 0; r < 4; r++)
            csr_write(r[1:0], rand_word());
         if (ph == 0)
            hold_kick <= 1'b1;
         push_ticks(200, 85);
         wait_drained();
      end

      repeat (300) @(posedge clock);
      if (err_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
